// ===== rtl/qsu_pkg.sv =====
`timescale 1ns / 1ps
// Package for the quoted string unescaper: codes, character constants and result type.
// Used by the channel interfaces and by quoted_string_unescaper_core.
package qsu_pkg;

  localparam int MAX_HELD_SPACES_DEF = 32;
  localparam int MAX_LENGTH_DEF      = 4096;

  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 13;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNF_ESCAPE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNCLOSED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd3;

  localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
  localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
  localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic                kind;
    logic [CHAR_W-1:0]   ch;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    len;
  } res_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ===== rtl/qsu_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input, result and configuration words.
// Field widths come from qsu_pkg.
interface qsu_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [qsu_pkg::CHAR_W-1:0] in_char;
  modport source (output valid, command, in_char, input ready);
  modport sink   (input valid, command, in_char, output ready);
endinterface

interface qsu_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [qsu_pkg::CHAR_W-1:0]   out_char;
  logic                        last_of_run;
  logic [qsu_pkg::STATUS_W-1:0] status;
  logic [qsu_pkg::LEN_W-1:0]    consumed_length;
  modport source (output valid, kind, out_char, last_of_run, status, consumed_length,
                  input ready);
  modport sink   (input valid, kind, out_char, last_of_run, status, consumed_length,
                  output ready);
endinterface

interface qsu_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [qsu_pkg::CHAR_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/quoted_string_unescaper_core.sv =====
`timescale 1ns / 1ps
// Quoted string unescaper top level; depends on qsu_pkg and the interfaces in qsu_ifs.sv.
// A word's first result passes the job registers, the e1 register and the result buffer.
// Throughput: one word per cycle while each word yields at most one result and the result
// buffer has room; a word releasing N held spaces and yielding M characters holds the input
// until its last result issues, since held-space reads and issues yield one result per cycle.
// Reset clears all decode state and the terminator; the held-space memory is not cleared.
module quoted_string_unescaper_core #(
  parameter int MAX_HELD_SPACES = qsu_pkg::MAX_HELD_SPACES_DEF,
  parameter int MAX_LENGTH      = qsu_pkg::MAX_LENGTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  qsu_in_if.sink    in_ch,
  qsu_out_if.source out_ch,
  qsu_cfg_if.sink   cfg_ch
);

  localparam int AW    = (MAX_HELD_SPACES > 1) ? $clog2(MAX_HELD_SPACES) : 1;
  localparam int HC_W  = $clog2(MAX_HELD_SPACES + 1);
  localparam int CW    = $clog2(MAX_LENGTH + 1);
  localparam int LXW   = (CW > qsu_pkg::LEN_W) ? CW : qsu_pkg::LEN_W;
  localparam int DEPTH = 4;
  localparam int FPW   = $clog2(DEPTH);
  localparam int FCW   = $clog2(DEPTH + 1);

  logic [qsu_pkg::CHAR_W-1:0] term_r;

  logic            inq_r, inq_nxt;
  logic            esc_r, esc_nxt;
  logic            seen_r, seen_nxt;
  logic            stop_r, stop_nxt;
  logic [qsu_pkg::STATUS_W-1:0] err_r, err_nxt;
  logic [HC_W-1:0] held_r, held_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [LXW-1:0]  cnt_ext;

  logic [qsu_pkg::CHAR_W-1:0] held_mem [MAX_HELD_SPACES];
  logic [qsu_pkg::CHAR_W-1:0] mem_rd_r;

  logic            job_active_r;
  logic [HC_W-1:0] job_idx_r, job_nflush_r;
  logic [qsu_pkg::CHAR_W-1:0] job_ch0_r, job_ch1_r;
  logic            job_two_r, job_end_r, job_chsel_r;
  logic [qsu_pkg::STATUS_W-1:0] job_status_r;
  logic [qsu_pkg::LEN_W-1:0]    job_len_r;

  logic            mk_job, nj_two, nj_end, hold_wr;
  logic [HC_W-1:0] nj_flush;
  logic [qsu_pkg::CHAR_W-1:0] nj_ch0, nj_ch1;
  logic [qsu_pkg::STATUS_W-1:0] nj_status;

  logic            in_acc, can_issue, in_flush, rd_issue, ch_issue, ch_last, job_done;
  logic [qsu_pkg::CHAR_W-1:0] c;

  logic            e1_v_r, e1_mem_r;
  qsu_pkg::res_t   e1_res_r, e1_res, iss_res;

  qsu_pkg::res_t   fifo [DEPTH];
  logic [FPW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FCW-1:0]  fifo_cnt_r;
  logic            pop;

  assign c        = in_ch.in_char;
  assign cnt_ext  = LXW'(cnt_r);
  assign cnt_inc  = (cnt_r < CW'(MAX_LENGTH)) ? cnt_r + CW'(1) : cnt_r;

  assign can_issue = job_active_r && ((fifo_cnt_r + FCW'(e1_v_r)) < FCW'(DEPTH));
  assign in_flush  = job_idx_r < job_nflush_r;
  assign rd_issue  = can_issue && in_flush;
  assign ch_issue  = can_issue && !in_flush;
  assign ch_last   = job_end_r || job_chsel_r || !job_two_r;
  assign job_done  = ch_issue && ch_last;

  assign in_ch.ready  = !job_active_r || job_done;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    inq_nxt   = inq_r;
    esc_nxt   = esc_r;
    seen_nxt  = seen_r;
    stop_nxt  = stop_r;
    err_nxt   = err_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    mk_job    = 1'b0;
    nj_two    = 1'b0;
    nj_end    = 1'b0;
    nj_flush  = '0;
    nj_ch0    = c;
    nj_ch1    = c;
    nj_status = qsu_pkg::ST_OK;
    hold_wr   = 1'b0;
    if (in_acc) begin
      if (in_ch.command == qsu_pkg::CMD_END) begin
        mk_job = 1'b1;
        nj_end = 1'b1;
        if (esc_r) begin
          nj_status = qsu_pkg::ST_UNF_ESCAPE;
        end else if (inq_r) begin
          nj_status = qsu_pkg::ST_UNCLOSED;
        end else begin
          nj_status = err_r;
        end
        inq_nxt  = 1'b0;
        esc_nxt  = 1'b0;
        seen_nxt = 1'b0;
        stop_nxt = 1'b0;
        err_nxt  = qsu_pkg::ST_OK;
        held_nxt = '0;
        cnt_nxt  = '0;
      end else if (!stop_r) begin
        if (!esc_r && !inq_r && (term_r != qsu_pkg::CH_NUL) && (c == term_r)) begin
          stop_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_inc;
          if (esc_r) begin
            esc_nxt  = 1'b0;
            mk_job   = 1'b1;
            nj_flush = held_r;
            held_nxt = '0;
            seen_nxt = 1'b1;
            case (c)
              qsu_pkg::CH_T: nj_ch0 = qsu_pkg::CH_TAB;
              qsu_pkg::CH_R: nj_ch0 = qsu_pkg::CH_CR;
              qsu_pkg::CH_N: nj_ch0 = qsu_pkg::CH_LF;
              default: begin
                nj_ch0 = qsu_pkg::CH_BSLASH;
                nj_two = 1'b1;
              end
            endcase
          end else if (c == qsu_pkg::CH_QUOTE) begin
            inq_nxt = !inq_r;
          end else if (c == qsu_pkg::CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else if (inq_r || !qsu_pkg::is_space(c)) begin
            mk_job   = 1'b1;
            nj_flush = held_r;
            held_nxt = '0;
            seen_nxt = 1'b1;
          end else if (seen_r) begin
            if (held_r < HC_W'(MAX_HELD_SPACES)) begin
              hold_wr  = 1'b1;
              held_nxt = held_r + HC_W'(1);
            end else begin
              err_nxt = qsu_pkg::ST_OVERFLOW;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r <= '0;
      inq_r  <= 1'b0;
      esc_r  <= 1'b0;
      seen_r <= 1'b0;
      stop_r <= 1'b0;
      err_r  <= qsu_pkg::ST_OK;
      held_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        term_r <= cfg_ch.data;
      end
      inq_r  <= inq_nxt;
      esc_r  <= esc_nxt;
      seen_r <= seen_nxt;
      stop_r <= stop_nxt;
      err_r  <= err_nxt;
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_wr) begin
      held_mem[held_r[AW-1:0]] <= c;
    end
    if (rd_issue) begin
      mem_rd_r <= held_mem[job_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_active_r <= 1'b0;
    end else if (in_acc && mk_job) begin
      job_active_r <= 1'b1;
    end else if (job_done) begin
      job_active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && mk_job) begin
      job_idx_r    <= '0;
      job_nflush_r <= nj_flush;
      job_ch0_r    <= nj_ch0;
      job_ch1_r    <= nj_ch1;
      job_two_r    <= nj_two;
      job_end_r    <= nj_end;
      job_chsel_r  <= 1'b0;
      job_status_r <= nj_status;
      job_len_r    <= cnt_ext[qsu_pkg::LEN_W-1:0];
    end else begin
      if (rd_issue) begin
        job_idx_r <= job_idx_r + HC_W'(1);
      end
      if (ch_issue) begin
        job_chsel_r <= 1'b1;
      end
    end
  end

  always_comb begin
    iss_res = '0;
    if (ch_issue) begin
      if (job_end_r) begin
        iss_res.kind   = qsu_pkg::KIND_END;
        iss_res.ch     = qsu_pkg::CH_NUL;
        iss_res.status = job_status_r;
        iss_res.len    = job_len_r;
      end else begin
        iss_res.kind = qsu_pkg::KIND_CHAR;
        iss_res.ch   = job_chsel_r ? job_ch1_r : job_ch0_r;
      end
      iss_res.last = ch_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
    end else begin
      e1_v_r <= can_issue;
    end
    e1_mem_r <= rd_issue;
    e1_res_r <= iss_res;
  end

  always_comb begin
    e1_res = e1_res_r;
    if (e1_mem_r) begin
      e1_res    = '0;
      e1_res.ch = mem_rd_r;
    end
  end

  assign pop = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (e1_v_r) begin
        wr_ptr_r <= wr_ptr_r + FPW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FPW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + FCW'(e1_v_r) - FCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (e1_v_r) begin
      fifo[wr_ptr_r] <= e1_res;
    end
  end

  assign out_ch.valid           = fifo_cnt_r != '0;
  assign out_ch.kind            = fifo[rd_ptr_r].kind;
  assign out_ch.out_char        = fifo[rd_ptr_r].ch;
  assign out_ch.last_of_run     = fifo[rd_ptr_r].last;
  assign out_ch.status          = fifo[rd_ptr_r].status;
  assign out_ch.consumed_length = fifo[rd_ptr_r].len;

  // The result buffer never takes more words than it holds.
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_cnt_r + FCW'(e1_v_r)) <= FCW'(DEPTH))
    else $error("result buffer overrun");

  // No held space is written while a release of held spaces is still reading the memory.
  a_hold_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    hold_wr |-> !(job_active_r && in_flush))
    else $error("held-space write during release");

  // An end marker returns the decode state to its reset value.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.command == qsu_pkg::CMD_END)) |=>
      (held_r == '0) && !esc_r && !inq_r && !stop_r && (cnt_r == '0))
    else $error("end marker left decode state");

  // An end report always closes the run of its word.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.kind == qsu_pkg::KIND_END)) |-> out_ch.last_of_run)
    else $error("end report without last mark");

  // An issued result is in the e1 stage register in the cycle after it is issued, bound for the buffer.
  a_issue_lands: assert property (@(posedge clk) disable iff (!rst_n)
    can_issue |=> e1_v_r)
    else $error("issued result lost");

endmodule
